// ===== rtl/asp_pkg.sv =====
// Shared widths, constants and helpers for the servo pulse mapper.
`timescale 1ns / 1ps

package asp_pkg;

    // Field widths
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 10;
    localparam int ANGLE_W  = 8;
    localparam int PULSE_W  = 10;

    // Default geometry of the sample store
    localparam int WINDOW_DEF   = 3;
    localparam int CHANNELS_DEF = 4;

    // Mapping constants
    localparam int ANGLE_MAX   = 180;
    localparam int ADC_FULL    = 1023;
    localparam int NARROW_BASE = 8;
    localparam int NARROW_SPAN = 30;
    localparam int NARROW_MIN  = 8;
    localparam int NARROW_MAX  = 38;
    localparam int WIDE_BASE   = 125;
    localparam int WIDE_SPAN   = 500;
    localparam int WIDE_MAX    = WIDE_BASE + WIDE_SPAN;

    // Serial divider geometry: numerator covers filtered * 180, divisor covers 1023
    localparam int DIV_NUM_W = 18;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Servos 0 and 3 are the narrow-range type
    function automatic logic is_narrow(input logic [CHAN_W-1:0] ch);
        return (ch == CHAN_W'(0)) || (ch == CHAN_W'(3));
    endfunction

    // Compare value at zero angle for the servo type
    function automatic logic [PULSE_W-1:0] pulse_base(input logic [CHAN_W-1:0] ch);
        return is_narrow(ch) ? PULSE_W'(NARROW_BASE) : PULSE_W'(WIDE_BASE);
    endfunction

endpackage

// ===== rtl/asp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module asp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/asp_serial_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module asp_serial_div
    import asp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] numerator,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 q_bit;

    // Bring down the next numerator bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
        q_bit    = (trial >= {1'b0, den_reg});
        rem_next = q_bit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        num_next = {num_reg[DIV_NUM_W-2:0], q_bit};
    end

    // Control: load on start, step until every bit is through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the numerator register fills with quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numerator;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== rtl/adc_servo_pulse_mapper.sv =====
// Top level: per-channel sample ring, floor mean and angle/pulse mapping.
`timescale 1ns / 1ps

// Each transferred sample is written to its channel's ring of WINDOW entries,
// the ring is read back one entry at a time, each through S_SUM_RD and then
// S_SUM_ACC, and summed, and the mean, the angle (mean*180/1023) and the
// pulse compare value are then worked out one after another on a shared
// bit-serial divider, one quotient bit a cycle, in three 18-bit divisions.
// The input is ready for the next sample in the cycle after the result is
// loaded into the output register. The store sits in a RAM with one valid
// flag per entry, cleared by reset, so no clearing pass is needed and
// unwritten entries count as zero. A channel at or beyond CHANNELS leaves
// the store alone and returns zero mean, zero angle, the zero-angle compare
// value and drive low. manual_drive only sets the drive flag.
module adc_servo_pulse_mapper
    import asp_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic                cfg_write_data,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [CHAN_W-1:0]   servo,
    output logic [SAMPLE_W-1:0] filtered,
    output logic [ANGLE_W-1:0]  angle,
    output logic [PULSE_W-1:0]  pulse_compare,
    output logic                drive
);

    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * ADC_FULL + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_WRITE   = 11'b000_0000_0010,
        S_SUM_RD  = 11'b000_0000_0100,
        S_SUM_ACC = 11'b000_0000_1000,
        S_AVG     = 11'b000_0001_0000,
        S_AVG_W   = 11'b000_0010_0000,
        S_ANG     = 11'b000_0100_0000,
        S_ANG_W   = 11'b000_1000_0000,
        S_PUL     = 11'b001_0000_0000,
        S_PUL_W   = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic                manual_drive_reg;
    logic [CHAN_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [CH_W-1:0]     ch_idx;
    logic [POS_W-1:0]    pos_reg [CHANNELS];
    logic [DEPTH-1:0]    valid_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                rd_valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] filtered_reg;
    logic [ANGLE_W-1:0]  angle_reg;
    logic [PULSE_W-1:0]  pulse_reg;
    logic                drive_reg;

    logic                result_valid_reg, result_valid_next;
    logic [CHAN_W-1:0]   servo_reg;
    logic [SAMPLE_W-1:0] filtered_out_reg;
    logic [ANGLE_W-1:0]  angle_out_reg;
    logic [PULSE_W-1:0]  pulse_out_reg;
    logic                drive_out_reg;

    logic                in_xfer;
    logic                in_range;
    logic                out_load;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic                last_entry;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    assign in_xfer    = sample_valid && !sample_stall;
    assign in_range   = (32'(channel) < CHANNELS);
    assign out_load   = (state_reg == S_OUT) && (!result_valid_reg || !result_stall);
    assign ch_idx     = CH_W'(ch_reg);
    assign wr_addr    = ADDR_W'(int'(ch_idx) * WINDOW + int'(pos_reg[ch_idx]));
    assign rd_addr    = ADDR_W'(int'(ch_idx) * WINDOW + int'(rd_cnt_reg));
    assign ram_wr_en  = (state_reg == S_WRITE);
    assign last_entry = (rd_cnt_reg == CNT_W'(WINDOW - 1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = in_range ? S_WRITE : S_OUT;
                end
            end
            S_WRITE:   state_next = S_SUM_RD;
            S_SUM_RD:  state_next = S_SUM_ACC;
            S_SUM_ACC: state_next = last_entry ? S_AVG : S_SUM_RD;
            S_AVG:     state_next = S_AVG_W;
            S_AVG_W:   state_next = div_done ? S_ANG : S_AVG_W;
            S_ANG:     state_next = S_ANG_W;
            S_ANG_W:   state_next = div_done ? S_PUL : S_ANG_W;
            S_PUL:     state_next = S_PUL_W;
            S_PUL_W:   state_next = div_done ? S_OUT : S_PUL_W;
            S_OUT:     state_next = out_load ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_drive_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            manual_drive_reg <= cfg_write_data;
        end
    end

    // Ring positions and entry valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (ram_wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
            if (pos_reg[ch_idx] == POS_W'(WINDOW - 1))
            begin
                pos_reg[ch_idx] <= '0;
            end
            else
            begin
                pos_reg[ch_idx] <= pos_reg[ch_idx] + 1'b1;
            end
        end
    end

    // Sample store
    asp_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(wr_addr),
        .wr_data(sample_reg),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Feed the shared divider for each of the three quotients
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DIV_DEN_W'(1);
        case (state_reg)
            S_AVG:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(sum_reg);
                div_den   = DIV_DEN_W'(WINDOW);
            end
            S_ANG:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(32'(filtered_reg) * ANGLE_MAX);
                div_den   = DIV_DEN_W'(ADC_FULL);
            end
            S_PUL:
            begin
                div_start = 1'b1;
                div_num   = is_narrow(ch_reg) ? DIV_NUM_W'(32'(angle_reg) * NARROW_SPAN)
                                              : DIV_NUM_W'(32'(angle_reg) * WIDE_SPAN);
                div_den   = DIV_DEN_W'(ANGLE_MAX);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    asp_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numerator(div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Working registers: capture the item, accumulate, take each quotient
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    ch_reg       <= channel;
                    sample_reg   <= sample;
                    filtered_reg <= '0;
                    angle_reg    <= '0;
                    pulse_reg    <= pulse_base(channel);
                    drive_reg    <= 1'b0;
                end
            end
            S_WRITE:
            begin
                sum_reg    <= '0;
                rd_cnt_reg <= '0;
            end
            S_SUM_RD:
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            S_SUM_ACC:
            begin
                if (rd_valid_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(rd_data);
                end
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            S_AVG_W:
            begin
                if (div_done)
                begin
                    filtered_reg <= div_quot[SAMPLE_W-1:0];
                end
            end
            S_ANG_W:
            begin
                if (div_done)
                begin
                    angle_reg <= div_quot[ANGLE_W-1:0];
                end
            end
            S_PUL_W:
            begin
                if (div_done)
                begin
                    pulse_reg <= pulse_base(ch_reg) + div_quot[PULSE_W-1:0];
                    drive_reg <= manual_drive_reg;
                end
            end
            default:
            begin
                drive_reg <= drive_reg;
            end
        endcase
    end

    // Output register: hold while stalled, drop once transferred
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            servo_reg        <= ch_reg;
            filtered_out_reg <= filtered_reg;
            angle_out_reg    <= angle_reg;
            pulse_out_reg    <= pulse_reg;
            drive_out_reg    <= drive_reg;
        end
    end

    assign sample_stall  = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign servo         = servo_reg;
    assign filtered      = filtered_out_reg;
    assign angle         = angle_out_reg;
    assign pulse_compare = pulse_out_reg;
    assign drive         = drive_out_reg;

endmodule

// ===== rtl/asp_checker.sv =====
// Port-level checks for the servo pulse mapper, bound to the top level.
`timescale 1ns / 1ps

module asp_checker
    import asp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_stall,
    input logic                result_valid,
    input logic                result_stall,
    input logic [CHAN_W-1:0]   servo,
    input logic [SAMPLE_W-1:0] filtered,
    input logic [ANGLE_W-1:0]  angle,
    input logic [PULSE_W-1:0]  pulse_compare,
    input logic                drive
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(servo) && $stable(filtered) && $stable(angle)
            && $stable(pulse_compare) && $stable(drive))
        else $error("stalled result changed");

    // One item in flight: a transfer blocks the input on the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("input not stalled after a transfer");

    // Angle never exceeds full scale
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> angle <= ANGLE_W'(ANGLE_MAX))
        else $error("angle out of range");

    // Compare value stays in the range of the servo's type
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (is_narrow(servo) && pulse_compare >= PULSE_W'(NARROW_MIN)
                              && pulse_compare <= PULSE_W'(NARROW_MAX))
            || (!is_narrow(servo) && pulse_compare >= PULSE_W'(WIDE_BASE)
                                  && pulse_compare <= PULSE_W'(WIDE_MAX)))
        else $error("pulse compare out of range");

endmodule

bind adc_servo_pulse_mapper asp_checker u_asp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .servo        (servo),
    .filtered     (filtered),
    .angle        (angle),
    .pulse_compare(pulse_compare),
    .drive        (drive)
);
